### rtl/core/windowed_pseudocolor_map_defines.svh
// Assertion macros for the windowed pseudocolor map RTL, used by its queue.
`ifndef WINDOWED_PSEUDOCOLOR_MAP_DEFINES_SVH
`define WINDOWED_PSEUDOCOLOR_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define WPCM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wpcm assertion failed");
`define WPCM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wpcm assertion failed");
`else
`define WPCM_ASSERT_SAME(label, ante, cons)
`define WPCM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/wpcm_pkg.sv
// Shared types and constants of the windowed pseudocolor map.
`default_nettype none
package wpcm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_BITS  = 17;
   localparam int SEL_BITS  = 5;
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [SEL_BITS-1:0] TABLE_COUNT = 5'd24;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TABLE_SELECT = 2'd0,
      CSR_WINDOW_LOW   = 2'd1,
      CSR_WINDOW_HIGH  = 2'd2
   } csr_index_type;

   typedef enum logic [SEL_BITS-1:0] {
      TBL_GREY          = 5'd0,
      TBL_GREY_INV      = 5'd1,
      TBL_TRI_BWB       = 5'd2,
      TBL_TRI_WBW       = 5'd3,
      TBL_RED           = 5'd4,
      TBL_RED_INV       = 5'd5,
      TBL_BLUE          = 5'd6,
      TBL_BLUE_INV      = 5'd7,
      TBL_GREEN         = 5'd8,
      TBL_GREEN_INV     = 5'd9,
      TBL_HOT           = 5'd10,
      TBL_HOT_INV       = 5'd11,
      TBL_CONTOUR       = 5'd12,
      TBL_CONTOUR_INV   = 5'd13,
      TBL_HOT_BLUE      = 5'd14,
      TBL_HOT_BLUE_INV  = 5'd15,
      TBL_HOT_GREEN     = 5'd16,
      TBL_HOT_GREEN_INV = 5'd17,
      TBL_SPECTRUM      = 5'd18,
      TBL_SPECTRUM_INV  = 5'd19,
      TBL_HSV_WHITE     = 5'd20,
      TBL_HSV_WHITE_INV = 5'd21,
      TBL_HSV           = 5'd22,
      TBL_HSV_INV       = 5'd23
   } table_type;

   // Classification of one item as it travels through the back end.
   typedef struct packed {
      table_type sel;
      logic      reflect;
      logic      invalid;
      logic      above;
      logic      zero;
   } item_ctl_type;

endpackage
`default_nettype wire

### rtl/core/windowed_pseudocolor_map.sv
// Top level of the windowed pseudocolor map.
`default_nettype none
// Windowed pseudocolor map: turns one signed sample per transfer into an
// RGBA pixel through one of 24 colour tables over the window
// [window_low, window_high]. The block takes one sample per clock and
// returns one pixel per clock unless a stall on rsp_ready holds it; a
// pixel is offered after its sample has left the input queue and passed
// through the 17 stages of the position divider that yields one quotient
// bit per stage, and five colour stages, whose last register is the
// output register. The front end classifies each sample against the
// window and writes a two-entry queue; the back end pipeline advances
// whenever the output register is empty or its pixel is being taken, so
// a stall on rsp_ready holds the whole back end and fills the queue
// before req_ready drops. Table codes 24 to 31 behave as the grey ramp.
// Write the CSR registers (0 table select, 1 window low, 2 window high)
// only while no samples are in flight; index 3 is ignored.
module windowed_pseudocolor_map import wpcm_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [SAMPLE_BITS-1:0]        csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  wire logic                          req_sample_invalid,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_red,
   output logic [7:0]                         rsp_green,
   output logic [7:0]                         rsp_blue,
   output logic [7:0]                         rsp_alpha
);

   localparam int CTL_BITS   = $bits(item_ctl_type);
   localparam int QUEUE_BITS = CTL_BITS + 2 * (SAMPLE_BITS + 1);

   // Front end: classify the sample against the window.
   item_ctl_type           front_ctl;
   logic [SAMPLE_BITS:0]   front_num, front_den;

   wpcm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sample_value     (req_sample_value),
      .sample_invalid   (req_sample_invalid),
      .ctl              (front_ctl),
      .num              (front_num),
      .den              (front_den)
   );

   // Queue decouples the front end from back-end stalls.
   logic                   queue_valid;
   logic [QUEUE_BITS-1:0]  queue_data;
   logic                   advance;
   item_ctl_type           back_ctl;
   logic [SAMPLE_BITS:0]   back_num, back_den;

   wpcm_queue #(.WIDTH(QUEUE_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  ({front_ctl, front_num, front_den}),
      .pop_valid  (queue_valid),
      .pop_ready  (advance),
      .pop_data   (queue_data)
   );

   assign back_ctl = item_ctl_type'(queue_data[QUEUE_BITS-1 -: CTL_BITS]);
   assign back_num = queue_data[2*SAMPLE_BITS+1 -: SAMPLE_BITS+1];
   assign back_den = queue_data[SAMPLE_BITS:0];

   // Advance the back end when the output register is free or drains now.
   assign advance = !rsp_valid || rsp_ready;

   item_ctl_type          div_ctl;
   logic                  div_valid;
   logic [POS_BITS-1:0]   div_pos;

   wpcm_divider #(.SAMPLE_BITS(SAMPLE_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (queue_valid),
      .in_ctl    (back_ctl),
      .in_num    (back_num),
      .in_den    (back_den),
      .out_valid (div_valid),
      .out_ctl   (div_ctl),
      .out_pos   (div_pos)
   );

   wpcm_color u_color (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_ctl    (div_ctl),
      .in_pos    (div_pos),
      .out_valid (rsp_valid),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue),
      .out_alpha (rsp_alpha)
   );

endmodule
`default_nettype wire

### rtl/core/wpcm_front.sv
// Front end: configuration registers and item classification.
`default_nettype none
module wpcm_front import wpcm_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [SAMPLE_BITS-1:0]        csr_write_data,
   input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
   input  wire logic                          sample_invalid,
   output item_ctl_type                       ctl,
   output logic [SAMPLE_BITS:0]               num,
   output logic [SAMPLE_BITS:0]               den
);

   localparam int EW = SAMPLE_BITS + 3;
   localparam logic [SAMPLE_BITS-1:0] HIGH_RESET = SAMPLE_BITS'(32767);

   logic [SEL_BITS-1:0]           table_select_ff;
   logic signed [SAMPLE_BITS-1:0] window_low_ff;
   logic signed [SAMPLE_BITS-1:0] window_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_select_ff <= '0;
         window_low_ff   <= '0;
         window_high_ff  <= HIGH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TABLE_SELECT: table_select_ff <= csr_write_data[SEL_BITS-1:0];
            CSR_WINDOW_LOW:   window_low_ff   <= csr_write_data;
            CSR_WINDOW_HIGH:  window_high_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [SEL_BITS-1:0]  sel_raw;
   logic [SEL_BITS-1:0]  sel_norm;
   logic                 reflect;
   logic signed [EW-1:0] low_x, high_x, d_x, dr_x, num_x, den_x, num_a, den_a;

   always_comb begin
      sel_raw = (table_select_ff >= TABLE_COUNT) ? SEL_BITS'(TBL_GREY) : table_select_ff;
      reflect = sel_raw[0] && (sel_raw != SEL_BITS'(TBL_TRI_WBW))
                && (sel_raw != SEL_BITS'(TBL_CONTOUR_INV));
      sel_norm = reflect ? {sel_raw[SEL_BITS-1:1], 1'b0} : sel_raw;

      low_x  = EW'(window_low_ff);
      high_x = EW'(window_high_ff);
      d_x    = sample_invalid ? low_x : EW'(sample_value);
      dr_x   = reflect ? (high_x + low_x - d_x) : d_x;
      num_x  = dr_x - low_x;
      den_x  = high_x - low_x;
      if (den_x < 0) begin
         num_a = -num_x;
         den_a = -den_x;
      end else begin
         num_a = num_x;
         den_a = den_x;
      end

      ctl.sel     = table_type'(sel_norm);
      ctl.reflect = reflect;
      ctl.invalid = sample_invalid;
      ctl.zero    = (num_a <= 0);
      ctl.above   = (num_a > 0) && (num_a > den_a);
      num = num_a[SAMPLE_BITS:0];
      den = den_a[SAMPLE_BITS:0];
   end

endmodule
`default_nettype wire

### rtl/core/wpcm_queue.sv
// Two-entry queue between front end and back end.
`default_nettype none
`include "windowed_pseudocolor_map_defines.svh"
module wpcm_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] entry_ff [0:DEPTH-1];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   always_comb begin
      push_ready = (count_ff != 2'(DEPTH));
      pop_valid  = (count_ff != 2'd0);
      pop_data   = entry_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `WPCM_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= 2'(DEPTH))
   `WPCM_ASSERT_NEXT(a_head_holds, pop_valid && !pop_ready, pop_valid && $stable(pop_data))
   `WPCM_ASSERT_NEXT(a_fill, push && !pop && count_ff == 2'd1, count_ff == 2'(DEPTH))

endmodule
`default_nettype wire

### rtl/core/wpcm_divider.sv
// Pipelined restoring divider: window position num/den as Q1.16.
`default_nettype none
module wpcm_divider import wpcm_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  item_ctl_type                in_ctl,
   input  wire logic [SAMPLE_BITS:0]   in_num,
   input  wire logic [SAMPLE_BITS:0]   in_den,
   output logic                        out_valid,
   output item_ctl_type                out_ctl,
   output logic [POS_BITS-1:0]         out_pos
);

   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1) << FRAC_BITS;

   logic                       valid_ff [0:FRAC_BITS];
   item_ctl_type               ctl_ff   [0:FRAC_BITS];
   logic [SAMPLE_BITS:0]       rem_ff   [0:FRAC_BITS];
   logic [SAMPLE_BITS:0]       den_ff   [0:FRAC_BITS];
   logic [POS_BITS-1:0]        quo_ff   [0:FRAC_BITS];

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_stage
      logic [SAMPLE_BITS+1:0] trial;
      logic [SAMPLE_BITS+1:0] diff;
      logic [SAMPLE_BITS:0]   den_src;
      logic [POS_BITS-1:0]    quo_src;
      logic [POS_BITS-1:0]    quo_in;
      logic [SAMPLE_BITS:0]   rem_in;
      item_ctl_type           ctl_src;
      logic                   valid_src;
      logic                   ge;

      if (k == 0) begin : g_first
         assign trial     = {1'b0, in_num};
         assign den_src   = in_den;
         assign quo_src   = '0;
         assign ctl_src   = in_ctl;
         assign valid_src = in_valid;
      end else begin : g_next
         assign trial     = {rem_ff[k-1], 1'b0};
         assign den_src   = den_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign ctl_src   = ctl_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      always_comb begin
         diff   = trial - {1'b0, den_src};
         ge     = (trial >= {1'b0, den_src});
         rem_in = ge ? diff[SAMPLE_BITS:0] : trial[SAMPLE_BITS:0];
         quo_in = quo_src;
         quo_in[FRAC_BITS-k] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_in;
            ctl_ff[k] <= ctl_src;
         end
      end
   end

   always_comb begin
      out_valid = valid_ff[FRAC_BITS];
      out_ctl   = ctl_ff[FRAC_BITS];
      if (ctl_ff[FRAC_BITS].zero) begin
         out_pos = '0;
      end else if (ctl_ff[FRAC_BITS].above) begin
         out_pos = POS_ONE;
      end else begin
         out_pos = quo_ff[FRAC_BITS];
      end
   end

endmodule
`default_nettype wire

### rtl/core/wpcm_color.sv
// Colour table evaluation pipeline with output register.
`default_nettype none
module wpcm_color import wpcm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  item_ctl_type             in_ctl,
   input  wire logic [POS_BITS-1:0] in_pos,
   output logic                     out_valid,
   output logic [7:0]               out_red,
   output logic [7:0]               out_green,
   output logic [7:0]               out_blue,
   output logic [7:0]               out_alpha
);

   localparam logic [24:0] TRI_HALF  = 25'd16711680;   // 255 << 16
   localparam logic [24:0] TRI_FOLD  = 25'd33488896;   // 511 << 16
   localparam logic [19:0] RED_KNEE  = 20'd458752;     // 7 << 16
   localparam logic [23:0] HOT_R_SAT = 24'd11927552;   // 182 << 16
   localparam logic [23:0] HOT_G_LO  = 24'd8388608;    // 128 << 16
   localparam logic [23:0] HOT_G_HI  = 24'd14352384;   // 219 << 16
   localparam logic [23:0] HOT_B_ON  = 24'd12582912;   // 192 << 16
   localparam logic [18:0] SIX_ONE   = 19'd393216;
   localparam logic [16:0] ONE       = 17'd65536;
   localparam logic [24:0] RECIP_255 = 25'd16843010;
   localparam logic [13:0] RECIP_7   = 14'd9363;
   localparam logic [16:0] RECIP_182 = 17'd92183;
   localparam logic [15:0] RECIP_91  = 16'd46092;
   localparam logic [14:0] RECIP_63  = 15'd16645;

   // ---------------- stage 1: ramps, triangle, hue position
   logic [23:0] ramp_prod;
   logic [24:0] u_raw, u_fold;
   logic [19:0] p_x10;
   logic [27:0] p_x2550;
   logic [18:0] hx6, hx5, hv5, hx;
   logic [16:0] hv;
   logic [24:0] full_prod;

   always_comb begin
      ramp_prod = 24'(in_pos) * 24'd255;
      u_raw     = 25'(in_pos) * 25'd510;
      u_fold    = (u_raw > TRI_HALF) ? (TRI_FOLD - u_raw) : u_raw;
      p_x10     = 20'(in_pos) * 20'd10;
      p_x2550   = 28'(in_pos) * 28'd2550;
      hx6       = 19'(in_pos) * 19'd6;
      hx5       = 19'(ONE - in_pos) * 19'd5;
      hv5       = 19'(in_pos) * 19'd5;
      if (in_ctl.sel == TBL_SPECTRUM) begin
         hx = (hx6 >= SIX_ONE) ? 19'd0 : hx6;
         hv = ONE;
      end else begin
         hx = hx5;
         hv = (hv5 > 19'(ONE)) ? ONE : hv5[16:0];
      end
      full_prod = 25'(hv) * 25'd255;
   end

   logic          s1_valid_ff;
   item_ctl_type  s1_ctl_ff;
   logic [16:0]   s1_pos_ff;
   logic [7:0]    s1_ramp_ff;
   logic [23:0]   s1_u_ff;
   logic          s1_red_hi_ff;
   logic [11:0]   s1_red_t_ff;
   logic [7:0]    s1_tg_ff;
   logic [2:0]    s1_sext_ff;
   logic [15:0]   s1_frac_ff;
   logic [16:0]   s1_hv_ff;
   logic [7:0]    s1_full_ff;
   logic          s1_white_ff;
   logic [24:0]   tg_diff;

   assign tg_diff = u_raw - TRI_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctl_ff    <= in_ctl;
         s1_pos_ff    <= in_pos;
         s1_ramp_ff   <= ramp_prod[23:16];
         s1_u_ff      <= in_ctl.above ? 24'd0 : u_fold[23:0];
         s1_red_hi_ff <= (p_x10 >= RED_KNEE);
         s1_red_t_ff  <= p_x2550[27:16];
         s1_tg_ff     <= in_pos[15] | in_pos[16] ? tg_diff[23:16] : 8'd0;
         s1_sext_ff   <= hx[18:16];
         s1_frac_ff   <= hx[15:0];
         s1_hv_ff     <= hv;
         s1_full_ff   <= full_prod[23:16];
         s1_white_ff  <= (in_ctl.sel == TBL_HSV_WHITE) && in_ctl.above;
      end
   end

   // ---------------- stage 2: contour divide, red ramp, hue products
   logic [23:0] cont_in;
   logic [48:0] cont_prod;
   logic [25:0] red_prod;
   logic [32:0] vf_prod;
   logic [33:0] vnf_prod;

   always_comb begin
      cont_in   = (s1_ctl_ff.sel == TBL_CONTOUR_INV) ? (24'd16711680 - s1_u_ff) : s1_u_ff;
      cont_prod = 49'(cont_in) * 49'(RECIP_255);
      red_prod  = 26'(s1_red_t_ff) * 26'(RECIP_7);
      vf_prod   = 33'(s1_hv_ff) * 33'(s1_frac_ff);
      vnf_prod  = 34'(s1_hv_ff) * 34'(ONE - 17'(s1_frac_ff));
   end

   logic          s2_valid_ff;
   item_ctl_type  s2_ctl_ff;
   logic [16:0]   s2_pos_ff;
   logic [16:0]   s2_cont_ff;
   logic [7:0]    s2_ramp_ff;
   logic [7:0]    s2_tri_ff;
   logic [7:0]    s2_red_ff;
   logic [7:0]    s2_tg_ff;
   logic [2:0]    s2_sext_ff;
   logic [32:0]   s2_vf_ff;
   logic [33:0]   s2_vnf_ff;
   logic [7:0]    s2_full_ff;
   logic          s2_white_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ctl_ff   <= s1_ctl_ff;
         s2_pos_ff   <= s1_pos_ff;
         s2_cont_ff  <= cont_prod[48:32];
         s2_ramp_ff  <= s1_ramp_ff;
         s2_tri_ff   <= s1_u_ff[23:16];
         s2_red_ff   <= s1_red_hi_ff ? 8'd255 : red_prod[23:16];
         s2_tg_ff    <= s1_tg_ff;
         s2_sext_ff  <= s1_sext_ff;
         s2_vf_ff    <= vf_prod;
         s2_vnf_ff   <= vnf_prod;
         s2_full_ff  <= s1_full_ff;
         s2_white_ff <= s1_white_ff;
      end
   end

   // ---------------- stage 3: hot metal breakpoints, hue ramps
   logic [16:0] p_hot;
   logic [23:0] s_hot, xg, xb;
   logic [31:0] tr_prod;
   logic [30:0] tg_prod;
   logic [29:0] tb_prod;
   logic [40:0] up_prod, down_prod;
   logic        contour;

   always_comb begin
      contour   = (s2_ctl_ff.sel == TBL_CONTOUR) || (s2_ctl_ff.sel == TBL_CONTOUR_INV);
      p_hot     = contour ? s2_cont_ff : s2_pos_ff;
      s_hot     = 24'(p_hot) * 24'd255;
      xg        = s_hot - HOT_G_LO;
      xb        = s_hot - HOT_B_ON;
      tr_prod   = 32'(s_hot) * 32'd255;
      tg_prod   = 31'(xg[22:0]) * 31'd255;
      tb_prod   = 30'(xb[21:0]) * 30'd255;
      up_prod   = 41'(s2_vf_ff) * 41'd255;
      down_prod = 41'(s2_vnf_ff) * 41'd255;
   end

   logic          s3_valid_ff;
   item_ctl_type  s3_ctl_ff;
   logic [7:0]    s3_ramp_ff, s3_ramp_hot_ff, s3_tri_ff, s3_red_ff, s3_tg_ff;
   logic          s3_r_sat_ff, s3_g_lo_ff, s3_g_hi_ff, s3_b_on_ff;
   logic [15:0]   s3_tr_ff;
   logic [14:0]   s3_thg_ff;
   logic [13:0]   s3_thb_ff;
   logic [2:0]    s3_sext_ff;
   logic [7:0]    s3_up_ff, s3_down_ff, s3_full_ff;
   logic          s3_white_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ctl_ff      <= s2_ctl_ff;
         s3_ramp_ff     <= s2_ramp_ff;
         s3_ramp_hot_ff <= s_hot[23:16];
         s3_tri_ff      <= s2_tri_ff;
         s3_red_ff      <= s2_red_ff;
         s3_tg_ff       <= s2_tg_ff;
         s3_r_sat_ff    <= (s_hot >= HOT_R_SAT);
         s3_g_lo_ff     <= (s_hot < HOT_G_LO);
         s3_g_hi_ff     <= (s_hot >= HOT_G_HI);
         s3_b_on_ff     <= (s_hot >= HOT_B_ON);
         s3_tr_ff       <= tr_prod[31:16];
         s3_thg_ff      <= tg_prod[30:16];
         s3_thb_ff      <= tb_prod[29:16];
         s3_sext_ff     <= s2_sext_ff;
         s3_up_ff       <= up_prod[39:32];
         s3_down_ff     <= down_prod[39:32];
         s3_full_ff     <= s2_full_ff;
         s3_white_ff    <= s2_white_ff;
      end
   end

   // ---------------- stage 4: hot metal channels, hue sextant
   logic [32:0] hr_prod;
   logic [30:0] hg_prod;
   logic [28:0] hb_prod;
   logic [7:0]  hsv_r, hsv_g, hsv_b;

   always_comb begin
      hr_prod = 33'(s3_tr_ff) * 33'(RECIP_182);
      hg_prod = 31'(s3_thg_ff) * 31'(RECIP_91);
      hb_prod = 29'(s3_thb_ff) * 29'(RECIP_63);
      if (s3_white_ff) begin
         hsv_r = 8'd255;
         hsv_g = 8'd255;
         hsv_b = 8'd255;
      end else begin
         case (s3_sext_ff)
            3'd0: begin
               hsv_r = s3_full_ff; hsv_g = s3_up_ff;   hsv_b = 8'd0;
            end
            3'd1: begin
               hsv_r = s3_down_ff; hsv_g = s3_full_ff; hsv_b = 8'd0;
            end
            3'd2: begin
               hsv_r = 8'd0;       hsv_g = s3_full_ff; hsv_b = s3_up_ff;
            end
            3'd3: begin
               hsv_r = 8'd0;       hsv_g = s3_down_ff; hsv_b = s3_full_ff;
            end
            3'd4: begin
               hsv_r = s3_up_ff;   hsv_g = 8'd0;       hsv_b = s3_full_ff;
            end
            default: begin
               hsv_r = s3_full_ff; hsv_g = 8'd0;       hsv_b = s3_down_ff;
            end
         endcase
      end
   end

   logic          s4_valid_ff;
   item_ctl_type  s4_ctl_ff;
   logic [7:0]    s4_ramp_ff, s4_ramp_hot_ff, s4_tri_ff, s4_red_ff, s4_tg_ff;
   logic [7:0]    s4_hr_ff, s4_hg_ff, s4_hb_ff;
   logic [7:0]    s4_sr_ff, s4_sg_ff, s4_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ctl_ff      <= s3_ctl_ff;
         s4_ramp_ff     <= s3_ramp_ff;
         s4_ramp_hot_ff <= s3_ramp_hot_ff;
         s4_tri_ff      <= s3_tri_ff;
         s4_red_ff      <= s3_red_ff;
         s4_tg_ff       <= s3_tg_ff;
         s4_hr_ff       <= s3_r_sat_ff ? 8'd255 : hr_prod[31:24];
         s4_hg_ff       <= s3_g_lo_ff ? 8'd0 : (s3_g_hi_ff ? 8'd255 : hg_prod[29:22]);
         s4_hb_ff       <= s3_b_on_ff ? hb_prod[27:20] : 8'd0;
         s4_sr_ff       <= hsv_r;
         s4_sg_ff       <= hsv_g;
         s4_sb_ff       <= hsv_b;
      end
   end

   // ---------------- stage 5: channel routing, alpha, output register
   logic [7:0] red_in, green_in, blue_in, alpha_in;

   always_comb begin
      case (s4_ctl_ff.sel)
         TBL_TRI_BWB: begin
            red_in = s4_tri_ff; green_in = s4_tri_ff; blue_in = s4_tri_ff;
            alpha_in = s4_tri_ff;
         end
         TBL_TRI_WBW: begin
            red_in = ~s4_tri_ff; green_in = ~s4_tri_ff; blue_in = ~s4_tri_ff;
            alpha_in = s4_tri_ff;
         end
         TBL_RED: begin
            red_in = s4_red_ff; green_in = s4_tg_ff; blue_in = s4_tg_ff;
            alpha_in = s4_ramp_ff;
         end
         TBL_BLUE: begin
            red_in = s4_tg_ff; green_in = s4_tg_ff; blue_in = s4_red_ff;
            alpha_in = s4_ramp_ff;
         end
         TBL_GREEN: begin
            red_in = s4_tg_ff; green_in = s4_red_ff; blue_in = s4_tg_ff;
            alpha_in = s4_ramp_ff;
         end
         TBL_HOT, TBL_CONTOUR: begin
            red_in = s4_hr_ff; green_in = s4_hg_ff; blue_in = s4_hb_ff;
            alpha_in = s4_ramp_hot_ff;
         end
         TBL_CONTOUR_INV: begin
            red_in = s4_hr_ff; green_in = s4_hg_ff; blue_in = s4_hb_ff;
            alpha_in = ~s4_ramp_hot_ff;
         end
         TBL_HOT_BLUE: begin
            red_in = s4_hb_ff; green_in = s4_hg_ff; blue_in = s4_hr_ff;
            alpha_in = s4_ramp_ff;
         end
         TBL_HOT_GREEN: begin
            red_in = s4_hg_ff; green_in = s4_hr_ff; blue_in = s4_hb_ff;
            alpha_in = s4_ramp_ff;
         end
         TBL_SPECTRUM, TBL_HSV_WHITE, TBL_HSV: begin
            red_in = s4_sr_ff; green_in = s4_sg_ff; blue_in = s4_sb_ff;
            alpha_in = s4_ramp_ff;
         end
         default: begin
            red_in = s4_ramp_ff; green_in = s4_ramp_ff; blue_in = s4_ramp_ff;
            alpha_in = s4_ramp_ff;
         end
      endcase
      if (s4_ctl_ff.reflect) begin
         alpha_in = ~alpha_in;
      end
      if (s4_ctl_ff.invalid) begin
         alpha_in = 8'd0;
      end
   end

   logic out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_red   <= red_in;
         out_green <= green_in;
         out_blue  <= blue_in;
         out_alpha <= alpha_in;
      end
   end

   assign out_valid = out_valid_ff;

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for the windowed pseudocolor map.
`default_nettype none
module tb;
   import wpcm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB = 16;
   localparam int LATENCY = 23;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [16:0] ONE = 17'h10000;

   typedef struct packed {
      logic signed [SB-1:0] value;
      logic                 invalid;
   } sample_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_TABLE_SELECT;
   logic [SB-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SB-1:0] req_sample_value = '0;
   logic req_sample_invalid = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_red, rsp_green, rsp_blue, rsp_alpha;

   windowed_pseudocolor_map #(.SAMPLE_BITS(SB)) u_top (.*);

   always #1 clock = ~clock;

   // Shadow copy of the configuration registers.
   table_type            cur_table;
   logic [4:0]           cur_sel_raw;
   logic signed [SB-1:0] cur_low, cur_high;

   sample_type sample_queue[$];
   pixel_type  pixel_queue[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_off = 0;
   bit sender_pause = 0;

   // ---------------------------------------------------------------------
   // Color math
   // ---------------------------------------------------------------------
   function automatic logic [31:0] ramp8(logic [31:0] p);
      logic [63:0] t;
      t = 64'(p) * 255;
      return 32'(t >> 16);
   endfunction

   // Q1.16 position of a sample in the window, with the above-top flag.
   function automatic logic [31:0] window_position(longint d, longint lo, longint hi,
                                                   output bit above);
      longint num, den;
      num = d - lo;
      den = hi - lo;
      above = 0;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (den == 0) begin
         if (num > 0) begin
            above = 1;
            return ONE;
         end
         return 0;
      end
      if (num <= 0) return 0;
      if (num > den) begin
         above = 1;
         return ONE;
      end
      return 32'((num << 16) / den);
   endfunction

   function automatic logic [31:0] triangle_q16(logic [31:0] p, bit above);
      logic [31:0] u;
      if (above) return 0;
      u = p * 510;
      if (u > (32'd255 << 16)) u = (32'd511 << 16) - u;
      return u;
   endfunction

   function automatic pixel_type temperature(logic [31:0] p);
      pixel_type o;
      longint q;
      q = p;
      o.red = (q * 10 >= 7 * 65536) ? 8'd255 : 8'((q * 2550) / (7 * 65536));
      o.green = (q >= 32768) ? 8'((q * 510 - 255 * 65536) >>> 16) : 8'd0;
      o.blue = o.green;
      o.alpha = 8'(ramp8(p));
      return o;
   endfunction

   function automatic pixel_type hot_metal(logic [31:0] p);
      pixel_type o;
      longint s;
      s = longint'(p) * 255;
      o.red = (s >= 182 * 65536) ? 8'd255 : 8'((s * 255) / (182 * 65536));
      if (s < 128 * 65536) o.green = 0;
      else if (s >= 219 * 65536) o.green = 255;
      else o.green = 8'(((s - 128 * 65536) * 255) / (91 * 65536));
      if (s >= 192 * 65536) o.blue = 8'(((s - 192 * 65536) * 255) / (63 * 65536));
      else o.blue = 0;
      o.alpha = 8'(ramp8(p));
      return o;
   endfunction

   function automatic pixel_type hsv_color(logic [31:0] hx, logic [31:0] v, bit sat);
      pixel_type o;
      logic [7:0] full, up, down;
      logic [31:0] f;
      logic [63:0] t;
      o = '0;
      full = 8'(ramp8(v));
      if (!sat) begin
         o.red = full;
         o.green = full;
         o.blue = full;
         return o;
      end
      if (hx >= 6 * 65536) hx = 0;
      f = hx & 32'hFFFF;
      t = 64'd255 * v * f;
      up = 8'(t >> 32);
      t = 64'd255 * v * (65536 - f);
      down = 8'(t >> 32);
      case (hx >> 16)
         0: begin o.red = full; o.green = up; end
         1: begin o.red = down; o.green = full; end
         2: begin o.green = full; o.blue = up; end
         3: begin o.green = down; o.blue = full; end
         4: begin o.red = up; o.blue = full; end
         default: begin o.red = full; o.blue = down; end
      endcase
      return o;
   endfunction

   // Expected pixel for one sample under the current configuration.
   function automatic pixel_type colorize(sample_type s);
      pixel_type o;
      logic [4:0] sel;
      logic [7:0] t8;
      logic [31:0] p, u, v;
      longint d;
      bit reflect, above;
      sel = cur_sel_raw;
      reflect = 0;
      d = s.invalid ? longint'(cur_low) : longint'(s.value);
      if (sel >= TABLE_COUNT) sel = TBL_GREY;
      if (sel[0] && sel != TBL_TRI_WBW && sel != TBL_CONTOUR_INV) begin
         reflect = 1;
         sel = sel - 1;
      end
      if (reflect) d = longint'(cur_high) + longint'(cur_low) - d;
      p = window_position(d, cur_low, cur_high, above);
      case (table_type'(sel))
         TBL_TRI_BWB, TBL_TRI_WBW: begin
            v = triangle_q16(p, above) >> 16;
            t8 = (sel == TBL_TRI_WBW) ? 8'(255 - v) : 8'(v);
            o = '{t8, t8, t8, 8'(v)};
         end
         TBL_RED, TBL_BLUE, TBL_GREEN: begin
            o = temperature(p);
            if (sel == TBL_BLUE) begin t8 = o.red; o.red = o.blue; o.blue = t8; end
            if (sel == TBL_GREEN) begin t8 = o.red; o.red = o.green; o.green = t8; end
         end
         TBL_HOT, TBL_HOT_BLUE, TBL_HOT_GREEN: begin
            o = hot_metal(p);
            if (sel == TBL_HOT_BLUE) begin t8 = o.red; o.red = o.blue; o.blue = t8; end
            if (sel == TBL_HOT_GREEN) begin t8 = o.red; o.red = o.green; o.green = t8; end
         end
         TBL_CONTOUR: o = hot_metal(triangle_q16(p, above) / 255);
         TBL_CONTOUR_INV: begin
            u = triangle_q16(p, above);
            o = hot_metal(((32'd255 << 16) - u) / 255);
            o.alpha = 8'(255 - o.alpha);
         end
         TBL_SPECTRUM: begin
            o = hsv_color(6 * p, ONE, 1);
            o.alpha = 8'(ramp8(p));
         end
         TBL_HSV_WHITE, TBL_HSV: begin
            v = 5 * p;
            if (v > ONE) v = ONE;
            if (sel == TBL_HSV_WHITE && above) o = hsv_color(0, ONE, 0);
            else o = hsv_color(5 * (ONE - p), v, 1);
            o.alpha = 8'(ramp8(p));
         end
         default: begin
            t8 = 8'(ramp8(p));
            o = '{t8, t8, t8, t8};
         end
      endcase
      if (reflect) o.alpha = 8'(255 - o.alpha);
      if (s.invalid) o.alpha = 0;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: bursts of transfers with random gaps
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      sample_type nxt;
      if (!reset) begin
         if (req_valid && req_ready) begin
            // Predict at acceptance, then retire the item.
            pixel_queue.push_back(colorize(sample_queue.pop_front()));
         end
         if (req_valid && !req_ready) begin
            // hold the offered sample until it is taken
         end else if (sample_queue.size() > 0 && !sender_pause && gap_left == 0) begin
            nxt = sample_queue[0];
            req_valid <= 1'b1;
            req_sample_value <= nxt.value;
            req_sample_invalid <= nxt.invalid;
            if (burst_left > 0) burst_left <= burst_left - 1;
            else begin
               burst_left <= $urandom_range(0, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: receiver stalls and result check
   // ---------------------------------------------------------------------
   int stall_phase = 0;
   always @(posedge clock) begin
      pixel_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_red, rsp_green, rsp_blue, rsp_alpha};
            if (pixel_queue.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) $display("unexpected pixel %h", got);
            end else begin
               want = pixel_queue.pop_front();
               if (got !== want) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("pixel mismatch: expected r%0d g%0d b%0d a%0d got r%0d g%0d b%0d a%0d",
                              want.red, want.green, want.blue, want.alpha,
                              got.red, got.green, got.blue, got.alpha);
               end
            end
         end
         // Long hold-off counted here; otherwise stall on a rotating pattern.
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            stall_phase <= (stall_phase + 1) % 64;
            rsp_ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout");
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [SB-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_TABLE_SELECT: cur_sel_raw = data[4:0];
         CSR_WINDOW_LOW: cur_low = data;
         default: cur_high = data;
      endcase
   endtask

   task automatic wait_drained();
      while (sample_queue.size() != 0 || req_valid || pixel_queue.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic sample_type pick_sample();
      sample_type s;
      int lo, hi, k;
      lo = (cur_low < cur_high) ? cur_low : cur_high;
      hi = (cur_low < cur_high) ? cur_high : cur_low;
      k = $urandom_range(0, 9);
      // mostly inside the window, with edges and full range mixed in
      if (k < 6) s.value = SB'($urandom_range(0, hi - lo) + lo);
      else if (k == 6) s.value = SB'(lo + $urandom_range(0, 2) - 1);
      else if (k == 7) s.value = SB'(hi + $urandom_range(0, 2) - 1);
      else s.value = SB'($urandom);
      s.invalid = ($urandom_range(0, 15) == 0);
      return s;
   endfunction

   initial begin
      logic signed [SB-1:0] lo, hi;
      cur_sel_raw = TBL_GREY;
      cur_low = 0;
      cur_high = 16'sd32767;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes and special cases under the reset window.
      sample_queue.push_back('{16'sh8000, 1'b0});
      sample_queue.push_back('{16'sh7FFF, 1'b0});
      sample_queue.push_back('{16'sh0000, 1'b0});
      sample_queue.push_back('{16'sh5555, 1'b0});
      sample_queue.push_back('{16'shAAAA, 1'b0});
      sample_queue.push_back('{16'sh7FFF, 1'b1});
      sample_queue.push_back('{16'sh4000, 1'b0});
      wait_drained();

      // Every table, including unused codes, over a small window and a
      // reversed one; then a zero-width window.
      for (int t = 0; t < 32; t++) begin
         csr_write(CSR_TABLE_SELECT, SB'(t));
         if (t == 0) begin
            csr_write(CSR_WINDOW_LOW, SB'(-100));
            csr_write(CSR_WINDOW_HIGH, SB'(100));
         end
         if (t == 16) begin
            csr_write(CSR_WINDOW_LOW, SB'(300));
            csr_write(CSR_WINDOW_HIGH, SB'(-50));
         end
         for (int k = 0; k < 6; k++) sample_queue.push_back(pick_sample());
         wait_drained();
      end
      csr_write(CSR_WINDOW_LOW, SB'(7));
      csr_write(CSR_WINDOW_HIGH, SB'(7));
      for (int t = 0; t < 24; t++) begin
         csr_write(CSR_TABLE_SELECT, SB'(t));
         sample_queue.push_back('{16'sd6, 1'b0});
         sample_queue.push_back('{16'sd7, 1'b0});
         sample_queue.push_back('{16'sd8, 1'b1});
         sample_queue.push_back('{16'sd8, 1'b0});
         wait_drained();
      end

      // Random phases: random table and window, extremes included.
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_TABLE_SELECT, SB'($urandom_range(0, 31)));
         case (ph % 4)
            0: begin lo = 16'sh8000; hi = 16'sh7FFF; end
            1: begin lo = 16'sh7FFF; hi = 16'sh8000; end
            default: begin lo = SB'($urandom); hi = lo + SB'($urandom_range(0, 4000)); end
         endcase
         csr_write(CSR_WINDOW_LOW, lo);
         csr_write(CSR_WINDOW_HIGH, hi);
         for (int k = 0; k < 50; k++) sample_queue.push_back(pick_sample());
         if (ph == 3) begin
            // Hold off the receiver while the sender keeps offering.
            hold_off = 200;
         end
         if (ph == 7) begin
            while (sample_queue.size() > 25) @(posedge clock);
            sender_pause = 1;
            while (req_valid || pixel_queue.size() != 0) @(posedge clock);
            sender_pause = 0;
         end
         wait_drained();
      end

      if (mismatch_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
